[design/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants and types for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TEMP     = 3'd0,
        REG_PRES_LO  = 3'd1,
        REG_PRES_HI  = 3'd2,
        REG_MIXED    = 3'd3,
        REG_HUM      = 3'd4
    } reg_idx_t;

    localparam logic [31:0] K_64000   = 32'd64000;
    localparam logic [31:0] K_1048576 = 32'd1048576;
    localparam logic [31:0] K_3125    = 32'd3125;
    localparam logic [31:0] K_SIGN    = 32'h8000_0000;
    localparam logic [31:0] K_32768   = 32'd32768;
    localparam logic [31:0] K_76800   = 32'd76800;
    localparam logic [31:0] K_2097152 = 32'd2097152;
    localparam logic [31:0] K_16384   = 32'd16384;
    localparam logic [31:0] K_8192    = 32'd8192;
    localparam logic [31:0] K_HUM_MAX = 32'd419430400;

    // Divider: one quotient bit per stage.
    localparam int DivBits = 32;

    // Side data carried through the divider: temperature, humidity product,
    // zero-divisor flag and big-numerator flag.
    localparam int DivTagW = 32 + 32 + 1 + 1;

    // Wrapping 32-bit product, low word only.
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

[design/esc_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_divider
// Pipelined restoring divider, one quotient bit per stage, with a tag of
// side data carried alongside. Advances when en is high.
// ----------------------------------------------------------------------------
module esc_divider
    import esc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  logic [31:0]        num,
    input  logic [31:0]        den,
    input  logic [DivTagW-1:0] tag_in,
    output logic               out_vld,
    output logic [31:0]        quo,
    output logic [DivTagW-1:0] tag_out
);

    logic [DivBits-1:0] vld_reg;
    logic [31:0]        num_reg [DivBits];
    logic [31:0]        den_reg [DivBits];
    logic [32:0]        rem_reg [DivBits];
    logic [31:0]        quo_reg [DivBits];
    logic [DivTagW-1:0] tag_reg [DivBits];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DivBits-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DivBits; s++)
            begin
                logic [32:0] rin;
                logic [31:0] nin;
                logic [31:0] din;
                logic [31:0] qin;
                logic [32:0] trial;
                if (s == 0)
                begin
                    rin = '0;
                    nin = num;
                    din = den;
                    qin = '0;
                    tag_reg[s] <= tag_in;
                end
                else
                begin
                    rin = rem_reg[s-1];
                    nin = num_reg[s-1];
                    din = den_reg[s-1];
                    qin = quo_reg[s-1];
                    tag_reg[s] <= tag_reg[s-1];
                end
                trial = {rin[31:0], nin[DivBits-1-s]};
                if (trial >= {1'b0, din})
                begin
                    rem_reg[s] <= trial - {1'b0, din};
                    quo_reg[s] <= {qin[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[s] <= trial;
                    quo_reg[s] <= {qin[30:0], 1'b0};
                end
                num_reg[s] <= nin;
                den_reg[s] <= din;
            end
        end
    end

    assign out_vld = vld_reg[DivBits-1];
    assign quo     = quo_reg[DivBits-1];
    assign tag_out = tag_reg[DivBits-1];

endmodule

[design/env_sensor_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of one raw temperature, pressure and humidity sample.
// ----------------------------------------------------------------------------
// Usage: an item of raw_temp, raw_pres and raw_hum is taken when in_valid is
// high and in_stall is low. One result of temp_centi, pres_pascal and hum_q10
// appears on out_valid and is taken when out_stall is low.
// The pipeline takes one item per cycle while in_stall is low. Each item goes
// through eight arithmetic stages ahead of the divider, 32 divider stages (one
// quotient bit each), four stages after it for the pressure correction and
// humidity finish, and the output register. The divider sets the depth.
// The whole pipeline advances together: while out_stall holds a waiting
// result, in_stall is raised and every stage holds, so nothing is lost or
// repeated. in_stall is low whenever the output register is empty or being
// emptied.
// Reset clears all valid bits and the five calibration registers to zero.
// Calibration is written through cfg_we, cfg_idx and cfg_data, one register
// per clock; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module env_sensor_compensation
    import esc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_idx,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [19:0]         raw_temp,
    input  logic [19:0]         raw_pres,
    input  logic [15:0]         raw_hum,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  temp_centi,
    output logic [31:0]         pres_pascal,
    output logic [16:0]         hum_q10
);

    logic [47:0] temp_c_reg;
    logic [63:0] pres_lo_reg;
    logic [63:0] pres_hi_reg;
    logic [47:0] mixed_reg;
    logic [39:0] hum_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_c_reg  <= '0;
            pres_lo_reg <= '0;
            pres_hi_reg <= '0;
            mixed_reg   <= '0;
            hum_c_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_TEMP:    temp_c_reg  <= cfg_data[47:0];
                REG_PRES_LO: pres_lo_reg <= cfg_data;
                REG_PRES_HI: pres_hi_reg <= cfg_data;
                REG_MIXED:   mixed_reg   <= cfg_data[47:0];
                REG_HUM:     hum_c_reg   <= cfg_data[39:0];
                default:     ;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    assign t1 = {16'd0, temp_c_reg[15:0]};
    assign t2 = sx16(temp_c_reg[31:16]);
    assign t3 = sx16(temp_c_reg[47:32]);
    assign p1 = {16'd0, pres_lo_reg[15:0]};
    assign p2 = sx16(pres_lo_reg[31:16]);
    assign p3 = sx16(pres_lo_reg[47:32]);
    assign p4 = sx16(pres_lo_reg[63:48]);
    assign p5 = sx16(pres_hi_reg[15:0]);
    assign p6 = sx16(pres_hi_reg[31:16]);
    assign p7 = sx16(pres_hi_reg[47:32]);
    assign p8 = sx16(pres_hi_reg[63:48]);
    assign p9 = sx16(mixed_reg[15:0]);
    assign h1 = {24'd0, mixed_reg[23:16]};
    assign h2 = sx16(mixed_reg[39:24]);
    assign h3 = {24'd0, mixed_reg[47:40]};
    assign h4 = sx16(hum_c_reg[15:0]);
    assign h5 = sx16(hum_c_reg[31:16]);
    assign h6 = sx8(hum_c_reg[39:32]);

    // The pipeline moves as one; it holds only when a result waits on a stall.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic [8:1] v_reg;

    // Stage 1: temperature differences and adc values.
    logic [31:0] s1_a_reg, s1_b_reg, s1_adcp_reg, s1_adch_reg;
    // Stage 2: temperature products.
    logic [31:0] s2_v1_reg, s2_bb_reg, s2_adcp_reg, s2_adch_reg;
    // Stage 3: fine temperature pieces.
    logic [31:0] s3_v1_reg, s3_v2_reg, s3_adcp_reg, s3_adch_reg;
    // Stage 4: fine temperature.
    logic [31:0] s4_fine_reg, s4_adcp_reg, s4_adch_reg;
    // Stage 5: first products of pressure and humidity.
    logic [31:0] s5_temp_reg, s5_pv1_reg, s5_qq_reg, s5_v1p5_reg, s5_p2v1_reg;
    logic [31:0] s5_x_reg, s5_hx5_reg, s5_xh6_reg, s5_xh3_reg, s5_adcp_reg;
    logic [31:0] s5_adch_reg;
    // Stage 6.
    logic [31:0] s6_temp_reg, s6_v2a_reg, s6_p3q_reg, s6_p2v1_reg, s6_adcp_reg;
    logic [31:0] s6_ha_reg, s6_hb_reg;
    // Stage 7.
    logic [31:0] s7_temp_reg, s7_v2_reg, s7_pv1_reg, s7_adcp_reg;
    logic [31:0] s7_ha_reg, s7_hb_reg;
    // Stage 8: divider operands and humidity products.
    logic [31:0] s8_temp_reg, s8_num_reg, s8_den_reg;
    logic [31:0] s8_ha_reg, s8_hb_reg;
    logic        s8_big_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[7:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [31:0] adct, v1a, qv, v2a, v1b, t;
            logic [31:0] pnum, hv1;
            adct = {12'd0, raw_temp};
            s1_a_reg    <= (adct >> 3) - (t1 << 1);
            s1_b_reg    <= (adct >> 4) - t1;
            s1_adcp_reg <= {12'd0, raw_pres};
            s1_adch_reg <= {16'd0, raw_hum};

            s2_v1_reg   <= asr(mul32(s1_a_reg, t2), 11);
            s2_bb_reg   <= asr(mul32(s1_b_reg, s1_b_reg), 12);
            s2_adcp_reg <= s1_adcp_reg;
            s2_adch_reg <= s1_adch_reg;

            s3_v1_reg   <= s2_v1_reg;
            s3_v2_reg   <= mul32(s2_bb_reg, t3);
            s3_adcp_reg <= s2_adcp_reg;
            s3_adch_reg <= s2_adch_reg;

            s4_fine_reg <= s3_v1_reg + asr(s3_v2_reg, 14);
            s4_adcp_reg <= s3_adcp_reg;
            s4_adch_reg <= s3_adch_reg;

            v1a = asr(s4_fine_reg, 1) - K_64000;
            qv  = asr(v1a, 2);
            s5_temp_reg <= asr(mul32(s4_fine_reg, 32'd5) + 32'd128, 8);
            s5_pv1_reg  <= v1a;
            s5_qq_reg   <= mul32(qv, qv);
            s5_v1p5_reg <= mul32(v1a, p5);
            s5_p2v1_reg <= mul32(p2, v1a);
            s5_x_reg    <= s4_fine_reg - K_76800;
            s5_hx5_reg  <= mul32(h5, s4_fine_reg - K_76800);
            s5_xh6_reg  <= asr(mul32(s4_fine_reg - K_76800, h6), 10);
            s5_xh3_reg  <= asr(mul32(s4_fine_reg - K_76800, h3), 11);
            s5_adcp_reg <= s4_adcp_reg;
            s5_adch_reg <= s4_adch_reg;

            s6_temp_reg <= s5_temp_reg;
            s6_v2a_reg  <= mul32(asr(s5_qq_reg, 11), p6) + (s5_v1p5_reg << 1);
            s6_p3q_reg  <= mul32(p3, asr(s5_qq_reg, 13));
            s6_p2v1_reg <= s5_p2v1_reg;
            s6_adcp_reg <= s5_adcp_reg;
            s6_ha_reg   <= asr(((s5_adch_reg << 14) - (h4 << 20) - s5_hx5_reg) + K_16384,
                               15);
            s6_hb_reg   <= mul32(s5_xh6_reg, s5_xh3_reg + K_32768);

            v2a = asr(s6_v2a_reg, 2) + (p4 << 16);
            v1b = asr(asr(s6_p3q_reg, 3) + asr(s6_p2v1_reg, 1), 18);
            s7_temp_reg <= s6_temp_reg;
            s7_v2_reg   <= v2a;
            s7_pv1_reg  <= mul32(K_32768 + v1b, p1);
            s7_adcp_reg <= s6_adcp_reg;
            s7_ha_reg   <= s6_ha_reg;
            s7_hb_reg   <= mul32(asr(s6_hb_reg, 10) + K_2097152, h2);

            t = asr(s7_pv1_reg, 15);
            pnum = mul32((K_1048576 - s7_adcp_reg) - asr(s7_v2_reg, 12), K_3125);
            s8_temp_reg <= s7_temp_reg;
            s8_den_reg  <= t;
            s8_big_reg  <= (pnum >= K_SIGN);
            s8_num_reg  <= (pnum >= K_SIGN) ? pnum : (pnum << 1);
            s8_ha_reg   <= s7_ha_reg;
            hv1 = asr(s7_hb_reg + K_8192, 14);
            s8_hb_reg   <= hv1;
        end
    end

    // The humidity product rides in the tag through the divider and is
    // finished in the stages after it.
    logic [31:0] hx_reg;
    logic [31:0] h9_reg;
    logic [31:0] h10;
    logic [31:0] q2_hx_reg, q3_hx_reg;
    logic [16:0] hum_fin;
    logic [31:0] hx;
    // h9_reg and q3_hx_reg both belong to the item held in stage q3.
    assign h10 = asr(h9_reg, 7);
    assign hx  = q3_hx_reg - asr(mul32(h10, h1), 4);
    always_comb
    begin
        logic [31:0] c;
        c = hx;
        if (c[31])
            c = '0;
        if (c > K_HUM_MAX)
            c = K_HUM_MAX;
        hum_fin = c[28:12];
    end

    logic [DivTagW-1:0] d_tag_out;
    logic               d_vld;
    logic [31:0]        d_quo;
    logic [31:0]        d_hx;

    esc_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v_reg[8]),
        .num     (s8_num_reg),
        .den     (s8_den_reg),
        .tag_in  ({s8_temp_reg, mul32(s8_ha_reg, s8_hb_reg), s8_den_reg == '0, s8_big_reg}),
        .out_vld (d_vld),
        .quo     (d_quo),
        .tag_out (d_tag_out)
    );
    assign d_hx = d_tag_out[33:2];

    // Post stages: pressure correction and humidity finish.
    logic [4:1]  w_reg;
    logic [31:0] q1_p_reg, q1_temp_reg;
    logic        q1_zero_reg;
    logic [31:0] q2_p_reg, q2_rr_reg, q2_p8_reg, q2_temp_reg;
    logic        q2_zero_reg;
    logic [31:0] q3_p_reg, q3_w1_reg, q3_w2_reg, q3_temp_reg;
    logic        q3_zero_reg;
    logic [31:0] q4_p_reg, q4_temp_reg;
    logic [16:0] q4_hum_reg;
    logic [31:0] q2_h9src;

    assign q2_h9src = asr(q2_hx_reg, 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            w_reg     <= {w_reg[3:1], d_vld};
            out_valid <= w_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [31:0] r;
            q1_p_reg    <= d_tag_out[0] ? (d_quo << 1) : d_quo;
            q1_temp_reg <= d_tag_out[65:34];
            q1_zero_reg <= d_tag_out[1];
            hx_reg      <= d_hx;

            r = q1_p_reg >> 3;
            q2_p_reg    <= q1_p_reg;
            q2_rr_reg   <= mul32(r, r) >> 13;
            q2_p8_reg   <= asr(mul32(q1_p_reg >> 2, p8), 13);
            q2_temp_reg <= q1_temp_reg;
            q2_zero_reg <= q1_zero_reg;
            q2_hx_reg   <= hx_reg;

            q3_p_reg    <= q2_p_reg;
            q3_w1_reg   <= asr(mul32(p9, q2_rr_reg), 12);
            q3_w2_reg   <= q2_p8_reg;
            q3_temp_reg <= q2_temp_reg;
            q3_zero_reg <= q2_zero_reg;
            q3_hx_reg   <= q2_hx_reg;
            h9_reg      <= mul32(q2_h9src, q2_h9src);

            q4_p_reg    <= q3_zero_reg ? '0 :
                           q3_p_reg + asr(q3_w1_reg + q3_w2_reg + p7, 4);
            q4_temp_reg <= q3_temp_reg;
            q4_hum_reg  <= hum_fin;

            pres_pascal <= q4_p_reg;
            temp_centi  <= q4_temp_reg;
            hum_q10     <= q4_hum_reg;
        end
    end

endmodule

[design/esc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the compensation block.
// ----------------------------------------------------------------------------
module esc_checker
    import esc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pres_pascal,
    input logic [16:0] hum_q10
);

    // A waiting result holds while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pres_pascal))
        else $error("stalled item changed");

    // Input is stalled exactly when a result waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");

    // Humidity never exceeds its clamp.
    a_hum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hum_q10 <= 17'd102400)
        else $error("humidity out of range");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pres_pascal (pres_pascal),
    .hum_q10     (hum_q10)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the environmental sensor compensation pipeline.
// Calibration sets are written between phases. Each raw measurement item is
// predicted with 32-bit wrapping arithmetic and checked field by field,
// under random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module testbench;
    import esc_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;
    localparam int PipeDepth = 46;
    localparam int CycleLimit = 1000000;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        pres_pascal;
        logic [16:0]        hum_q10;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [19:0] raw_temp = '0;
    logic [19:0] raw_pres = '0;
    logic [15:0] raw_hum = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] temp_centi;
    logic [31:0] pres_pascal;
    logic [16:0] hum_q10;

    // Calibration words as the block should hold them.
    logic [63:0] cal_temp = '0, cal_pres_lo = '0, cal_pres_hi = '0;
    logic [63:0] cal_mixed = '0, cal_hum = '0;

    reading_t pending_readings[$];
    int mismatches = 0;
    int items_sent = 0;
    int readings_seen = 0;
    int zero_div_seen = 0;
    int clamp_seen = 0;
    int cycles = 0;
    bit calm = 1'b0;
    int hold_cycles = 0;

    env_sensor_compensation u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles with %0d readings outstanding.",
                     cycles, pending_readings.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] ashr(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] s16(input logic [63:0] w, input int pos);
        logic [15:0] f;
        f = w[pos +: 16];
        return {{16{f[15]}}, f};
    endfunction

    function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                            input logic [15:0] rh);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, fine, v1, v2, q, qq, p, r, w1, w2, x;
        reading_t res;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = s16(cal_temp, 16);
        t3 = s16(cal_temp, 32);
        p1 = {16'd0, cal_pres_lo[15:0]};
        p2 = s16(cal_pres_lo, 16);
        p3 = s16(cal_pres_lo, 32);
        p4 = s16(cal_pres_lo, 48);
        p5 = s16(cal_pres_hi, 0);
        p6 = s16(cal_pres_hi, 16);
        p7 = s16(cal_pres_hi, 32);
        p8 = s16(cal_pres_hi, 48);
        p9 = s16(cal_mixed, 0);
        h1 = {24'd0, cal_mixed[23:16]};
        h2 = s16(cal_mixed, 24);
        h3 = {24'd0, cal_mixed[47:40]};
        h4 = s16(cal_hum, 0);
        h5 = s16(cal_hum, 16);
        h6 = {{24{cal_hum[39]}}, cal_hum[39:32]};

        a = ({12'd0, rt} >> 3) - (t1 << 1);
        v1 = ashr(a * t2, 11);
        b = ({12'd0, rt} >> 4) - t1;
        v2 = ashr(ashr(b * b, 12) * t3, 14);
        fine = v1 + v2;
        res.temp_centi = ashr(fine * 32'd5 + 32'd128, 8);

        v1 = ashr(fine, 1) - K_64000;
        q = ashr(v1, 2);
        qq = q * q;
        v2 = ashr(qq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = ashr(v2, 2) + (p4 << 16);
        v1 = ashr(ashr(p3 * ashr(qq, 13), 3) + ashr(p2 * v1, 1), 18);
        v1 = ashr((K_32768 + v1) * p1, 15);
        if (v1 == 32'd0)
        begin
            p = 32'd0;
        end
        else
        begin
            p = ((K_1048576 - {12'd0, rp}) - ashr(v2, 12)) * K_3125;
            if (p < K_SIGN)
                p = (p << 1) / v1;
            else
                p = (p / v1) * 32'd2;
            r = p >> 3;
            w1 = ashr(p9 * ((r * r) >> 13), 12);
            w2 = ashr((p >> 2) * p8, 13);
            p = p + ashr(w1 + w2 + p7, 4);
        end
        res.pres_pascal = p;

        x = fine - K_76800;
        a = ashr((({16'd0, rh} << 14) - (h4 << 20) - (h5 * x)) + K_16384, 15);
        b = ashr(x * h6, 10) * (ashr(x * h3, 11) + K_32768);
        b = ashr(b, 10) + K_2097152;
        b = ashr(b * h2 + K_8192, 14);
        x = a * b;
        x = x - ashr(ashr(ashr(x, 15) * ashr(x, 15), 7) * h1, 4);
        if (x[31])
            x = 32'd0;
        if (x > K_HUM_MAX)
            x = K_HUM_MAX;
        res.hum_q10 = x[28:12];
        return res;
    endfunction

    // Most gaps are short; now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (calm)
                out_stall = 1'b0;
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 299) == 0)
                stall_left = $urandom_range(10, 50);
            else
                out_stall = ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected reading: temp %0d pres %0d hum %0d",
                             temp_centi, pres_pascal, hum_q10);
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (exp_r.pres_pascal == 32'd0)
                    zero_div_seen++;
                if (exp_r.hum_q10 == 17'd102400 || exp_r.hum_q10 == 17'd0)
                    clamp_seen++;
                if (temp_centi !== exp_r.temp_centi || pres_pascal !== exp_r.pres_pascal
                    || hum_q10 !== exp_r.hum_q10)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at reading %0d: temp %0d/%0d pres %0d/%0d hum %0d/%0d (exp/got)",
                                 readings_seen, exp_r.temp_centi, temp_centi,
                                 exp_r.pres_pascal, pres_pascal, exp_r.hum_q10, hum_q10);
                end
            end
        end
    end

    task automatic send_item(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        raw_temp = t;
        raw_pres = p;
        raw_hum = h;
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(compensate(t, p, h));
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_item();
        send_item(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    // Waits for the pipeline to empty before the calibration may change.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        case (idx)
            REG_TEMP:    cal_temp = {16'd0, data[47:0]};
            REG_PRES_LO: cal_pres_lo = data;
            REG_PRES_HI: cal_pres_hi = data;
            REG_MIXED:   cal_mixed = {16'd0, data[47:0]};
            REG_HUM:     cal_hum = {24'd0, data[39:0]};
            default:     ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic [63:0] w4);
        write_reg(REG_TEMP, w0);
        write_reg(REG_PRES_LO, w1);
        write_reg(REG_PRES_HI, w2);
        write_reg(REG_MIXED, w3);
        write_reg(REG_HUM, w4);
    endtask

    // A calibration set close to that of a real part.
    task automatic write_typical();
        write_all({16'hFC18, 16'd26435, 16'd27504},
                  {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                  {8'd0, 16'd362, 8'd75, 16'd6000},
                  {8'd30, 16'd50, 16'd313});
    endtask

    // With every coefficient zero the pressure divisor is zero.
    task automatic test_reset_calibration();
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'd519888, 20'd415148, 16'd28000);
        drain();
    endtask

    task automatic test_typical_extremes();
        write_typical();
        send_item(20'd519888, 20'd415148, 16'd28000);
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'd0, 20'hFFFFF, 16'hFFFF);
        send_item(20'hFFFFF, 20'd0, 16'd0);
        send_item(20'h80000, 20'h7FFFF, 16'h8000);
        send_item(20'd500000, 20'd300000, 16'd5000);
        send_item(20'd540000, 20'd500000, 16'd60000);
        drain();
    endtask

    // Coefficient fields at their sign boundaries; also spare indexes.
    task automatic test_coefficient_extremes();
        write_all('1, '1, '1, '1, '1);
        write_reg(REG_SPARE_5, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_SPARE_7, '1);
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        drain();
        write_all({16'h8000, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h8000}},
                  {8'hFF, 16'h8000, 8'hFF, 16'h8000}, {8'h80, 16'h8000, 16'h8000});
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'h55555, 20'hAAAAA, 16'h5555);
        drain();
        write_all({16'h7FFF, 16'h7FFF, 16'h0000}, {4{16'h7FFF}}, {4{16'h7FFF}},
                  {8'h00, 16'h7FFF, 8'h00, 16'h7FFF}, {8'h7F, 16'h7FFF, 16'h7FFF});
        send_item(20'd0, 20'd0, 16'd0);
        send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_item(20'hAAAAA, 20'h55555, 16'hAAAA);
        drain();
    endtask

    task automatic test_random_phases();
        logic [63:0] w[5];
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 3 == 0)
                write_typical();
            else
            begin
                foreach (w[i])
                    w[i] = {$urandom, $urandom};
                write_all(w[0], w[1], w[2], w[3], w[4]);
            end
            calm = (ph % 4 == 3);
            for (int n = 0; n < 100; n++)
            begin
                if (ph % 3 == 0 && $urandom_range(0, 3) != 0)
                    send_item(20'($urandom_range(400000, 600000)),
                              20'($urandom_range(250000, 450000)),
                              16'($urandom_range(15000, 45000)));
                else
                    send_random_item();
            end
            calm = 1'b0;
            drain();
        end
    endtask

    // The receiver holds off long enough for the whole pipeline to fill.
    task automatic test_backpressure();
        write_typical();
        calm = 1'b1;
        hold_cycles = 300;
        for (int n = 0; n < 120; n++)
            send_random_item();
        calm = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_reset_calibration();
        test_typical_extremes();
        test_coefficient_extremes();
        test_random_phases();
        test_backpressure();
        if (pending_readings.size() != 0)
            mismatches++;
        $display("Sent %0d items and checked %0d readings over 18 calibration sets.",
                 items_sent, readings_seen);
        $display("Zero divisor readings: %0d, humidity at a limit: %0d, mismatches: %0d.",
                 zero_div_seen, clamp_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/esc_pkg.sv
design/esc_divider.sv
design/env_sensor_compensation.sv
design/esc_checker.sv
bench/testbench.sv
